FILE: design/rfid_tag_zone_tally_assert.svh
// Assertion macros for the tag zone tally checker.
`ifndef RFID_TAG_ZONE_TALLY_ASSERT_SVH
`define RFID_TAG_ZONE_TALLY_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RTZ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rtz check failed");
// Check that also runs during reset.
`define RTZ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("rtz check failed");
`endif

FILE: design/rtz_pkg.sv
// Shared types, codes and constants for the tag zone tally.
`timescale 1ns / 1ps
package rtz_pkg;
  localparam int DEFAULT_DEPTH = 256;
  localparam logic [6:0]  THRESH_RESET = 7'd70;
  localparam logic [15:0] MIN_READS_RESET = 16'd3;
  localparam logic [23:0] MAX_READS = 24'hFFFFFF;
  localparam logic [15:0] MAX_ROUNDS = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0, OP_PRELOAD = 2'd1, OP_OBSERVE = 2'd2, OP_READ = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] ZONE_UPPER = 2'd0;
  localparam logic [1:0] ZONE_LOWER = 2'd1;
  localparam logic [1:0] ZONE_NONE = 2'd2;

  localparam logic [2:0] V_UNKNOWN = 3'd0;
  localparam logic [2:0] V_NOT_READ = 3'd1;
  localparam logic [2:0] V_UNCERTAIN = 3'd2;
  localparam logic [2:0] V_STABLE = 3'd3;
  localparam logic [2:0] V_CROSS = 3'd4;
  localparam logic [2:0] V_REVERSED = 3'd5;

  // Configuration register indexes.
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_MIN_READS = 1'b1;

  // One input word as it waits in the queue.
  typedef struct packed {
    logic [1:0]  op;
    logic [95:0] epc;
    logic        layer;
    logic        side;
    logic [15:0] cnt;
    logic [7:0]  idx;
  } item_t;
endpackage

FILE: design/rtz_front.sv
// Input side: accepts words and holds them in a two-entry queue.
`timescale 1ns / 1ps
module rtz_front
  import rtz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] epc_high,
  input  logic [63:0] epc_low,
  input  logic        preload_layer,
  input  logic        side,
  input  logic [15:0] burst_reads,
  input  logic [7:0]  entry_index,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  item_t     slots [2];
  logic      wptr, rptr;
  logic [1:0] fill;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      fill <= fill + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slots[wptr] <= '{op: op, epc: {epc_high, epc_low}, layer: preload_layer,
                       side: side, cnt: burst_reads, idx: entry_index};
    end
  end
endmodule

FILE: design/rtz_back.sv
// Execution side: table search, update, serial percent divide and result register.
`timescale 1ns / 1ps
module rtz_back
  import rtz_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  input  logic [6:0]  thresh,
  input  logic [15:0] min_reads,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [8:0]  entry_count,
  output logic [1:0]  expected_zone,
  output logic [23:0] upper_reads,
  output logic [23:0] lower_reads,
  output logic [15:0] upper_rounds,
  output logic [15:0] lower_rounds,
  output logic [1:0]  main_zone,
  output logic [6:0]  confidence,
  output logic [2:0]  verdict
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam int TW = 25;
  localparam int NW = TW + 7;

  typedef struct packed {
    logic [1:0]  exp;
    logic [23:0] ur;
    logic [23:0] lr;
    logic [15:0] urn;
    logic [15:0] lrn;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_CMP = 8'b00000100,
    S_ENT = 8'b00001000, S_UPD = 8'b00010000, S_DIV = 8'b00100000,
    S_FIN = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  logic [95:0] ids  [TABLE_DEPTH];
  entry_t      ents [TABLE_DEPTH];

  state_t        state;
  logic [CW-1:0] occ;
  logic [CW-1:0] scan;
  item_t         it;
  logic [95:0]   id_rd;
  entry_t        ent_rd, ent;
  entry_t        upd;
  logic [24:0]   sum;
  logic [AW-1:0] slot;
  logic          is_new;
  logic [NW-1:0] num;
  logic [TW-1:0] den, rem;
  logic [6:0]    quo;
  logic [5:0]    dcnt;
  logic [TW:0]   trial;

  assign q_ready = (state == S_IDLE) && !out_valid;
  assign trial   = {rem, num[NW-1]} - {1'b0, den};

  // Table memories: one read and one write port each.
  always_ff @(posedge clk) begin
    id_rd  <= ids[scan[AW-1:0]];
    ent_rd <= ents[(state == S_READ) ? scan[AW-1:0] : slot];
    if (state == S_UPD && it.op != OP_READ) begin
      ents[slot] <= upd;
      if (is_new) ids[slot] <= it.epc;
    end
  end

  // Working entry updated from the item.
  always_comb begin
    if (is_new) begin
      upd = '0;
      upd.exp = ZONE_NONE;
    end else begin
      upd = ent_rd;
    end
    sum = '0;
    if (it.op == OP_PRELOAD) begin
      upd.exp = {1'b0, it.layer};
    end else if (it.op == OP_OBSERVE) begin
      if (!it.side) begin
        sum = {1'b0, upd.ur} + 25'(it.cnt);
        upd.ur = sum[24] ? MAX_READS : sum[23:0];
        if (upd.urn != MAX_ROUNDS) upd.urn = upd.urn + 16'd1;
      end else begin
        sum = {1'b0, upd.lr} + 25'(it.cnt);
        upd.lr = sum[24] ? MAX_READS : sum[23:0];
        if (upd.lrn != MAX_ROUNDS) upd.lrn = upd.lrn + 16'd1;
      end
    end
  end

  logic          up_main;
  logic [23:0]   main_r, other_r;
  logic [TW-1:0] total;
  assign up_main = ent.ur >= ent.lr;
  assign main_r  = up_main ? ent.ur : ent.lr;
  assign other_r = up_main ? ent.lr : ent.ur;
  assign total   = {1'b0, ent.ur} + {1'b0, ent.lr};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            it    <= q_item;
            scan  <= '0;
            unique case (q_item.op)
              OP_CLEAR: begin
                occ <= '0;
                status <= ST_OK;
                entry_count <= '0;
                {expected_zone, upper_reads, lower_reads, upper_rounds,
                 lower_rounds, confidence} <= '0;
                main_zone <= ZONE_UPPER;
                verdict <= V_UNKNOWN;
                state <= S_OUT;
              end
              OP_READ: begin
                if ({1'b0, q_item.idx} >= 9'(occ) ||
                    CW'(q_item.idx) >= DEPTH_C) begin
                  status <= ST_RANGE;
                  entry_count <= 9'(occ);
                  {expected_zone, upper_reads, lower_reads, upper_rounds,
                   lower_rounds, confidence, main_zone, verdict} <= '0;
                  state <= S_OUT;
                end else begin
                  slot   <= AW'(q_item.idx);
                  is_new <= 1'b0;
                  state  <= S_ENT;
                end
              end
              default: state <= (occ == '0) ? S_ENT : S_READ;
            endcase
            if (q_item.op != OP_CLEAR && q_item.op != OP_READ && occ == '0) begin
              slot   <= '0;
              is_new <= 1'b1;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (id_rd == it.epc) begin
            slot <= scan[AW-1:0]; is_new <= 1'b0; state <= S_ENT;
          end else if (scan + 1'b1 == occ) begin
            if (occ == DEPTH_C) begin
              status <= ST_FULL;
              entry_count <= 9'(occ);
              {expected_zone, upper_reads, lower_reads, upper_rounds,
               lower_rounds, confidence, main_zone, verdict} <= '0;
              state <= S_OUT;
            end else begin
              slot <= occ[AW-1:0]; is_new <= 1'b1; state <= S_ENT;
            end
          end else begin
            scan <= scan + 1'b1; state <= S_READ;
          end
        end
        S_ENT: state <= S_UPD;
        S_UPD: begin
          ent <= (it.op == OP_READ) ? ent_rd : upd;
          if (is_new) occ <= occ + 1'b1;
          state <= S_DIV;
          dcnt <= '0;
        end
        S_DIV: begin
          // Restoring divide of main*100 by total, one quotient bit a cycle.
          if (dcnt == 6'd0) begin
            num <= NW'(main_r) * NW'(100);
            den <= total;
            rem <= '0;
            quo <= '0;
            dcnt <= 6'd1;
            if (total == '0) state <= S_FIN;
          end else begin
            if (!trial[TW]) rem <= trial[TW-1:0];
            else rem <= {rem[TW-2:0], num[NW-1]};
            num <= {num[NW-2:0], 1'b0};
            quo <= {quo[5:0], !trial[TW]};
            dcnt <= dcnt + 6'd1;
            if (dcnt == 6'(NW)) state <= S_FIN;
          end
        end
        S_FIN: begin
          status <= ST_OK;
          entry_count <= 9'(occ);
          expected_zone <= ent.exp;
          upper_reads <= ent.ur;
          lower_reads <= ent.lr;
          upper_rounds <= ent.urn;
          lower_rounds <= ent.lrn;
          confidence <= (total == '0) ? 7'd0 : quo;
          main_zone <= (total == '0) ? ZONE_NONE : (up_main ? ZONE_UPPER : ZONE_LOWER);
          if (ent.exp == ZONE_NONE) verdict <= V_UNKNOWN;
          else if (total == '0) verdict <= V_NOT_READ;
          else if (quo < thresh || main_r < 24'(min_reads)) verdict <= V_UNCERTAIN;
          else if ((up_main ? ZONE_UPPER : ZONE_LOWER) == ent.exp)
            verdict <= (other_r != '0) ? V_CROSS : V_STABLE;
          else verdict <= V_REVERSED;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/rfid_tag_zone_tally.sv
// Top level of the RFID tag zone tally.
`timescale 1ns / 1ps
// Keeps up to TABLE_DEPTH tags keyed by 96-bit EPC; each word returns one result
// word. A front queue of two words takes input while the back end works. The back
// end reads and compares the occupied slots in order, one slot at a time (one memory
// read port), then runs a bit-serial percent divide (cut short when the entry has no
// reads). A read goes straight to its entry; clear and out-of-range reads go straight
// to the result word, and a new tag on a full table ends the search with status full.
// The back end takes the next word the cycle after its result word is accepted.
module rfid_tag_zone_tally
  import rtz_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] epc_high,
  input  logic [63:0] epc_low,
  input  logic        preload_layer,
  input  logic        side,
  input  logic [15:0] burst_reads,
  input  logic [7:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [8:0]  entry_count,
  output logic [1:0]  expected_zone,
  output logic [23:0] upper_reads,
  output logic [23:0] lower_reads,
  output logic [15:0] upper_rounds,
  output logic [15:0] lower_rounds,
  output logic [1:0]  main_zone,
  output logic [6:0]  confidence,
  output logic [2:0]  verdict
);
  logic [6:0]  thresh;
  logic [15:0] min_reads;
  logic        q_valid, q_ready;
  item_t       q_item;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= THRESH_RESET;
      min_reads <= MIN_READS_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == 1'b0) begin
      if (paddr[2] == REG_THRESH) thresh <= pwdata[6:0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_MIN_READS) min_reads <= pwdata[15:0];
    end
  end

  // Register readback.
  always_comb begin
    if (paddr[1:0] != 2'b00) begin
      prdata = '0;
    end else begin
      unique case (paddr[2])
        REG_THRESH: prdata = {25'd0, thresh};
        REG_MIN_READS: prdata = {16'd0, min_reads};
      endcase
    end
  end

  rtz_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .epc_high, .epc_low, .preload_layer,
    .side, .burst_reads, .entry_index, .q_valid, .q_ready, .q_item
  );

  rtz_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .thresh, .min_reads, .out_valid,
    .out_ready, .status, .entry_count, .expected_zone, .upper_reads, .lower_reads,
    .upper_rounds, .lower_rounds, .main_zone, .confidence, .verdict
  );
endmodule

FILE: design/rtz_checker.sv
// Port-level checker for the tag zone tally, bound to the top level.
`timescale 1ns / 1ps
`include "rfid_tag_zone_tally_assert.svh"
module rtz_checker
  import rtz_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [8:0] entry_count,
  input logic [6:0] confidence,
  input logic [2:0] verdict
);
  `RTZ_ASSERT_ALWAYS(a_pready, clk, pready)
  `RTZ_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(verdict))
  `RTZ_ASSERT(a_conf, clk, rst, out_valid |-> confidence <= 7'd100 && verdict <= V_REVERSED)
  `RTZ_ASSERT(a_err_zero, clk, rst, out_valid && status != ST_OK |-> verdict == V_UNKNOWN && confidence == 7'd0)
  `RTZ_ASSERT(a_count, clk, rst, out_valid |-> entry_count <= 9'd256)
endmodule

bind rfid_tag_zone_tally rtz_checker u_rtz_checker (
  .clk, .rst, .pready, .out_valid, .out_ready, .status, .entry_count, .confidence,
  .verdict
);
